// ===== design/arq_pkg.sv =====
package arq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int HANDLE_W    = 16;
	localparam int COUNT_W     = 32;

	// Command codes (code 7 is ignored)
	typedef enum logic [2:0] {
		CMD_OUTBOUND   = 3'd0,
		CMD_INBOUND    = 3'd1,
		CMD_ENABLE     = 3'd2,
		CMD_ENABLED    = 3'd3,
		CMD_FAILED     = 3'd4,
		CMD_ACK_REQ    = 3'd5,
		CMD_ACK_ANSWER = 3'd6
	} cmd_t;

	// Message kinds
	typedef enum logic [1:0] {
		KIND_ENABLE = 2'd0,
		KIND_REQ    = 2'd1,
		KIND_ANSWER = 2'd2,
		KIND_RESEND = 2'd3
	} kind_t;

	// Stream management mode
	typedef enum logic [1:0] {
		MODE_DISABLED  = 2'd0,
		MODE_REQUESTED = 2'd1,
		MODE_ENABLED   = 2'd2
	} mode_t;

endpackage

// ===== design/arq_ram.sv =====
module arq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ack_retransmit_queue.sv =====
// Acknowledged-delivery bookkeeping: mode, inbound and confirmed counters and a FIFO of
// QUEUE_DEPTH handles of unacknowledged outbound items. A command is taken when start is
// high and busy is low; busy then stays high while the command runs. Each result is shown
// for exactly one cycle with strobe high and cannot be held off, so the receiver must take
// every beat as it comes. Most commands run as a capture step and an execute step; an ack
// answer does a subtract and compare in its execute step and then a pop step. Enable adds
// one drain step per queued handle: the queue is drained through the handle RAM's single
// read port, one resent handle per cycle, and results trail the execute cycle by one register stage.
module ack_retransmit_queue
	import arq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          cmd,
	input  logic                is_stanza,
	input  logic [HANDLE_W-1:0] item_handle,
	input  logic                has_count,
	input  logic [COUNT_W-1:0]  peer_count,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [HANDLE_W-1:0] resend_handle,
	output logic [COUNT_W-1:0]  ack_value,
	output logic                full_notice,
	output logic [1:0]          mode_now,
	output logic [5:0]          queue_level,
	output logic                last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN,
		S_POP
	} state_t;

	state_t state_q;

	// Captured command
	logic [2:0]          cmd_q;
	logic                stanza_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                has_count_q;
	logic [COUNT_W-1:0]  peer_q;

	// Block state
	mode_t               mode_q;
	logic [COUNT_W-1:0]  inbound_q;
	logic [COUNT_W-1:0]  confirmed_q;
	logic [PTR_W-1:0]    head_q;
	logic [LVL_W-1:0]    level_q;
	logic [LVL_W-1:0]    pop_cnt_q;

	// Result registers
	logic                strobe_q;
	kind_t               kind_q;
	logic [HANDLE_W-1:0] resend_q;
	logic [COUNT_W-1:0]  ack_q;
	logic                full_q;
	mode_t               mode_out_q;
	logic [LVL_W-1:0]    level_out_q;
	logic                last_q;

	// Datapath
	logic [HANDLE_W-1:0] rd_data;
	logic [PTR_W-1:0]    wr_addr;
	logic                wr_en;
	logic [LVL_W:0]      wr_sum;
	logic [LVL_W:0]      pop_sum;
	logic [PTR_W-1:0]    pop_head;
	logic [PTR_W-1:0]    head_inc;
	logic [COUNT_W-1:0]  diff;
	logic [LVL_W-1:0]    pop_calc;
	logic                push_ok;

	// Tail address: head + level, wrapped once
	always_comb begin
		wr_sum = (LVL_W+1)'(head_q) + (LVL_W+1)'(level_q);
		if (wr_sum >= (LVL_W+1)'(QUEUE_DEPTH)) begin
			wr_sum = wr_sum - (LVL_W+1)'(QUEUE_DEPTH);
		end
		wr_addr = wr_sum[PTR_W-1:0];
	end

	// Head after popping pop_cnt_q entries
	always_comb begin
		pop_sum = (LVL_W+1)'(head_q) + (LVL_W+1)'(pop_cnt_q);
		if (pop_sum >= (LVL_W+1)'(QUEUE_DEPTH)) begin
			pop_sum = pop_sum - (LVL_W+1)'(QUEUE_DEPTH);
		end
		pop_head = pop_sum[PTR_W-1:0];
	end

	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Subtract/compare: entries to pop on an ack answer
	always_comb begin
		diff     = peer_q - confirmed_q;
		pop_calc = '0;
		if (has_count_q && (peer_q > confirmed_q)) begin
			if (diff < COUNT_W'(level_q)) begin
				pop_calc = diff[LVL_W-1:0];
			end else begin
				pop_calc = level_q;
			end
		end
	end

	assign push_ok = (state_q == S_EXEC) && (cmd_t'(cmd_q) == CMD_OUTBOUND) && stanza_q &&
		(mode_q != MODE_DISABLED) && (level_q < LVL_W'(QUEUE_DEPTH));
	assign wr_en = push_ok;

	arq_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (handle_q),
		.raddr (head_q),
		.rdata (rd_data)
	);

	// Sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			stanza_q    <= 1'b0;
			handle_q    <= '0;
			has_count_q <= 1'b0;
			peer_q      <= '0;
			mode_q      <= MODE_DISABLED;
			inbound_q   <= '0;
			confirmed_q <= '0;
			head_q      <= '0;
			level_q     <= '0;
			pop_cnt_q   <= '0;
			strobe_q    <= 1'b0;
			kind_q      <= KIND_ENABLE;
			resend_q    <= '0;
			ack_q       <= '0;
			full_q      <= 1'b0;
			mode_out_q  <= MODE_DISABLED;
			level_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q       <= cmd;
						stanza_q    <= is_stanza;
						handle_q    <= item_handle;
						has_count_q <= has_count;
						peer_q      <= peer_count;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					unique case (cmd_t'(cmd_q))
						CMD_OUTBOUND: begin
							if (stanza_q && (mode_q != MODE_DISABLED)) begin
								strobe_q    <= 1'b1;
								kind_q      <= KIND_REQ;
								resend_q    <= '0;
								ack_q       <= '0;
								mode_out_q  <= mode_q;
								last_q      <= 1'b1;
								if (push_ok) begin
									level_q     <= level_q + 1'b1;
									level_out_q <= level_q + 1'b1;
									full_q      <= (level_q + 1'b1) == LVL_W'(QUEUE_DEPTH);
								end else begin
									level_out_q <= level_q;
									full_q      <= 1'b0;
								end
							end
						end
						CMD_INBOUND: begin
							if (stanza_q) begin
								inbound_q <= inbound_q + 1'b1;
							end
						end
						CMD_ENABLE: begin
							strobe_q    <= 1'b1;
							kind_q      <= KIND_ENABLE;
							resend_q    <= '0;
							ack_q       <= '0;
							full_q      <= 1'b0;
							mode_out_q  <= MODE_REQUESTED;
							level_out_q <= '0;
							last_q      <= (level_q == '0);
							confirmed_q <= '0;
							mode_q      <= MODE_REQUESTED;
							// RAM is already reading the head entry
							if (level_q != '0) begin
								head_q  <= head_inc;
								state_q <= S_DRAIN;
							end
						end
						CMD_ENABLED: begin
							inbound_q <= '0;
							mode_q    <= MODE_ENABLED;
						end
						CMD_FAILED: begin
							mode_q  <= MODE_DISABLED;
							level_q <= '0;
							head_q  <= '0;
						end
						CMD_ACK_REQ: begin
							if (mode_q == MODE_ENABLED) begin
								strobe_q    <= 1'b1;
								kind_q      <= KIND_ANSWER;
								resend_q    <= '0;
								ack_q       <= inbound_q;
								full_q      <= 1'b0;
								mode_out_q  <= mode_q;
								level_out_q <= level_q;
								last_q      <= 1'b1;
							end
						end
						CMD_ACK_ANSWER: begin
							pop_cnt_q <= pop_calc;
							if (has_count_q) begin
								confirmed_q <= peer_q;
							end
							state_q <= S_POP;
						end
						default: begin
						end
					endcase
				end
				S_DRAIN: begin
					// One resent handle per beat
					strobe_q    <= 1'b1;
					kind_q      <= KIND_RESEND;
					resend_q    <= rd_data;
					ack_q       <= '0;
					full_q      <= 1'b0;
					mode_out_q  <= mode_q;
					level_out_q <= '0;
					last_q      <= (level_q == LVL_W'(1));
					level_q     <= level_q - 1'b1;
					if (level_q == LVL_W'(1)) begin
						state_q <= S_IDLE;
					end else begin
						head_q <= head_inc;
					end
				end
				S_POP: begin
					head_q  <= pop_head;
					level_q <= level_q - pop_cnt_q;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign resend_handle = resend_q;
	assign ack_value     = ack_q;
	assign full_notice   = full_q;
	assign mode_now      = mode_out_q;
	assign queue_level   = 6'(level_out_q);
	assign last          = last_q;

endmodule
